// ----- rtl/protobuf_varint_field_extract_unit_assert.svh -----
// Assertion macros for the protobuf varint field extractor.
// Used by the top level; needs no other file.
`ifndef PROTOBUF_VARINT_FIELD_EXTRACT_UNIT_ASSERT_SVH
`define PROTOBUF_VARINT_FIELD_EXTRACT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define PVFE_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define PVFE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pvfe_pkg.sv -----
// Shared types and constants for the protobuf varint field extractor.
// No dependencies; imported by every module of the block.
package pvfe_pkg;

  localparam int MSG_BYTE_W          = 8;
  localparam int FIELD_NUM_W         = 29;
  localparam int OUTCOME_W           = 3;
  localparam int VALUE_W             = 32;
  localparam int ACCUM_W             = 64;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [FIELD_NUM_W-1:0] WANTED_RESET = FIELD_NUM_W'(1);

  // Varint limits
  localparam logic [3:0] MAX_VARINT_BYTES = 4'd10;

  // Wire types
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_I64    = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_I32    = 3'd5;

  // Fixed-width skip lengths
  localparam logic [ACCUM_W-1:0] SKIP_I64 = ACCUM_W'(8);
  localparam logic [ACCUM_W-1:0] SKIP_I32 = ACCUM_W'(4);

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_FOUND      = 3'd0,
    OUT_ABSENT     = 3'd1,
    OUT_WRONG_TYPE = 3'd2,
    OUT_UNSUP_TYPE = 3'd3,
    OUT_TOO_LONG   = 3'd4,
    OUT_TRUNC      = 3'd5
  } pvfe_outcome_t;

  typedef enum logic [2:0] {
    PH_KEY       = 3'd0,
    PH_VALUE     = 3'd1,
    PH_SKIPVAR   = 3'd2,
    PH_LEN       = 3'd3,
    PH_SKIPBYTES = 3'd4
  } pvfe_phase_t;

  // A classified message byte as held in the queue
  typedef struct packed {
    logic [6:0] data;
    logic       cont;
    logic       last;
  } pvfe_byte_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pvfe_q_status_t;

  typedef struct packed {
    logic pop;
  } pvfe_back_ctl_t;

endpackage

// ----- rtl/pvfe_if.sv -----
// Valid/ready channel interfaces for message bytes and results.
// Depends on pvfe_pkg for field widths.
interface pvfe_byte_if;
  logic                             valid;
  logic                             ready;
  logic [pvfe_pkg::MSG_BYTE_W-1:0]  msg_byte;
  logic                             msg_last;

  modport source (output valid, output msg_byte, output msg_last, input ready);
  modport sink   (input valid, input msg_byte, input msg_last, output ready);
endinterface

interface pvfe_result_if;
  logic                             valid;
  logic                             ready;
  logic [pvfe_pkg::OUTCOME_W-1:0]   outcome;
  logic signed [pvfe_pkg::VALUE_W-1:0] field_value;

  modport source (output valid, output outcome, output field_value, input ready);
  modport sink   (input valid, input outcome, input field_value, output ready);
endinterface

// ----- rtl/pvfe_front.sv -----
// Front end: accepts message bytes and splits them into payload and flags.
// Depends on pvfe_pkg and pvfe_byte_if.
module pvfe_front (
  pvfe_byte_if.sink                msg,
  input  pvfe_pkg::pvfe_q_status_t q_status,
  output logic                     push,
  output pvfe_pkg::pvfe_byte_t     push_data
);
  import pvfe_pkg::*;

  // Take a byte whenever the queue has room
  assign msg.ready = !q_status.full;
  assign push      = msg.valid && !q_status.full;

  // Classify: 7 payload bits, continuation bit, end of message
  always_comb begin
    push_data.data = msg.msg_byte[6:0];
    push_data.cont = msg.msg_byte[7];
    push_data.last = msg.msg_last;
  end

endmodule

// ----- rtl/pvfe_queue.sv -----
// Short FIFO between the front and back ends of the field extractor.
// Depends on pvfe_pkg for the entry type.
module pvfe_queue #(
  parameter int DEPTH = pvfe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  pvfe_pkg::pvfe_byte_t     push_data,
  input  pvfe_pkg::pvfe_back_ctl_t ctl,
  output pvfe_pkg::pvfe_byte_t     pop_data,
  output pvfe_pkg::pvfe_q_status_t status
);
  import pvfe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pvfe_byte_t          entries [DEPTH];
  logic [AW-1:0]       wr_ptr;
  logic [AW-1:0]       rd_ptr;
  logic [CW-1:0]       count;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (ctl.pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !ctl.pop) count <= count + CW'(1);
      else if (!push && ctl.pop) count <= count - CW'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  assign pop_data     = entries[rd_ptr];
  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);

endmodule

// ----- rtl/pvfe_back.sv -----
// Back end: wire-format parser and result register.
// Depends on pvfe_pkg and pvfe_result_if.
module pvfe_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [pvfe_pkg::FIELD_NUM_W-1:0] cfg_wr_data,
  input  pvfe_pkg::pvfe_q_status_t       q_status,
  input  pvfe_pkg::pvfe_byte_t           q_data,
  output pvfe_pkg::pvfe_back_ctl_t       ctl,
  pvfe_result_if.source                  res
);
  import pvfe_pkg::*;

  logic [FIELD_NUM_W-1:0] wanted;
  pvfe_phase_t            phase, phase_next;
  logic [ACCUM_W-1:0]     accum, accum_next;
  logic [3:0]             cnt, cnt_next;
  logic [ACCUM_W-1:0]     skip_rem, skip_next;
  logic                   sent, sent_next;

  logic                   res_valid;
  pvfe_outcome_t          res_outcome;
  logic [VALUE_W-1:0]     res_value;

  logic                   emit;
  pvfe_outcome_t          emit_code;
  logic [VALUE_W-1:0]     emit_value;

  logic [5:0]             shamt;
  logic [ACCUM_W-1:0]     v_now;
  logic [3:0]             cnt_inc;
  logic [ACCUM_W-1:0]     rem_dec;
  logic [2:0]             wt;
  logic                   fn_match;
  logic                   pop;

  // Pop when a byte waits and the result slot is free or being drained
  assign pop     = !q_status.empty && (!res_valid || res.ready);
  assign ctl.pop = pop;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) wanted <= WANTED_RESET;
    else if (cfg_wr_en) wanted <= cfg_wr_data;
  end

  // Varint assembly with the incoming byte
  assign shamt    = 6'(cnt) * 6'd7;
  assign v_now    = accum | (ACCUM_W'(q_data.data) << shamt);
  assign cnt_inc  = cnt + 4'd1;
  assign rem_dec  = (skip_rem != '0) ? skip_rem - ACCUM_W'(1) : skip_rem;
  assign wt       = v_now[2:0];
  assign fn_match = (v_now[ACCUM_W-1:FIELD_NUM_W+3] == '0) &&
                    (v_now[FIELD_NUM_W+2:3] == wanted);

  // Parser next state and result
  always_comb begin
    phase_next = phase;
    accum_next = accum;
    cnt_next   = cnt;
    skip_next  = skip_rem;
    sent_next  = sent;
    emit       = 1'b0;
    emit_code  = OUT_ABSENT;
    emit_value = '0;

    if (sent) begin
      // dropping bytes after the result, up to the end of the message
    end else if (phase == PH_SKIPBYTES) begin
      skip_next = rem_dec;
      if (rem_dec == '0) phase_next = PH_KEY;
      if (q_data.last) emit = 1'b1;
    end else begin
      accum_next = v_now;
      if (q_data.cont) begin
        cnt_next = cnt_inc;
        if (cnt_inc >= MAX_VARINT_BYTES) begin
          emit      = 1'b1;
          emit_code = OUT_TOO_LONG;
        end else if (q_data.last) begin
          emit      = 1'b1;
          emit_code = OUT_TRUNC;
        end
      end else begin
        accum_next = '0;
        cnt_next   = '0;
        case (phase)
          PH_VALUE: begin
            emit       = 1'b1;
            emit_code  = OUT_FOUND;
            emit_value = v_now[VALUE_W-1:0];
          end
          PH_SKIPVAR: begin
            phase_next = PH_KEY;
            emit       = q_data.last;
          end
          PH_LEN: begin
            if (v_now == '0) begin
              phase_next = PH_KEY;
            end else begin
              skip_next  = v_now;
              phase_next = PH_SKIPBYTES;
            end
            emit = q_data.last;
          end
          default: begin
            // key varint
            if (fn_match) begin
              if (wt == WT_VARINT) begin
                phase_next = PH_VALUE;
                emit       = q_data.last;
                emit_code  = OUT_TRUNC;
              end else begin
                emit      = 1'b1;
                emit_code = OUT_WRONG_TYPE;
              end
            end else if (wt == WT_VARINT) begin
              phase_next = PH_SKIPVAR;
              emit       = q_data.last;
              emit_code  = OUT_TRUNC;
            end else if (wt == WT_LEN) begin
              phase_next = PH_LEN;
              emit       = q_data.last;
              emit_code  = OUT_TRUNC;
            end else if (wt inside {WT_I64, WT_I32}) begin
              skip_next  = (wt == WT_I64) ? SKIP_I64 : SKIP_I32;
              phase_next = PH_SKIPBYTES;
              emit       = q_data.last;
            end else begin
              emit      = 1'b1;
              emit_code = OUT_UNSUP_TYPE;
            end
          end
        endcase
      end
    end

    // End of message clears the parse; an early result mutes the rest
    if (q_data.last) begin
      phase_next = PH_KEY;
      accum_next = '0;
      cnt_next   = '0;
      skip_next  = '0;
      sent_next  = 1'b0;
    end else if (emit) begin
      phase_next = PH_KEY;
      accum_next = '0;
      cnt_next   = '0;
      skip_next  = '0;
      sent_next  = 1'b1;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_KEY;
      accum    <= '0;
      cnt      <= '0;
      skip_rem <= '0;
      sent     <= 1'b0;
    end else if (pop) begin
      phase    <= phase_next;
      accum    <= accum_next;
      cnt      <= cnt_next;
      skip_rem <= skip_next;
      sent     <= sent_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_outcome <= emit_code;
      res_value   <= emit_value;
    end
  end

  assign res.valid       = res_valid;
  assign res.outcome     = res_outcome;
  assign res.field_value = res_value;

endmodule

// ----- rtl/protobuf_varint_field_extract_unit.sv -----
// Top level of the protobuf varint field extractor.
// Depends on pvfe_pkg, pvfe_if, pvfe_front, pvfe_queue, pvfe_back and the assert header.
//
// Takes one message byte per cycle while the queue has room and gives one result
// per message: the low 32 bits of the first varint field whose number matches the
// wanted field number, or the reason it was not found. Each byte is handled by
// the parser of the back end, whose per-byte state update sets the rate; bytes
// sit in a QUEUE_DEPTH-entry queue, so input keeps flowing for that many bytes
// while a result waits. A result is registered when its deciding byte leaves the
// queue. Bytes after the deciding one, up to the end of the message, are dropped.
`include "protobuf_varint_field_extract_unit_assert.svh"

module protobuf_varint_field_extract_unit #(
  parameter int QUEUE_DEPTH = pvfe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [pvfe_pkg::FIELD_NUM_W-1:0] cfg_wr_data,
  pvfe_byte_if.sink                        msg,
  pvfe_result_if.source                    res
);
  import pvfe_pkg::*;

  pvfe_q_status_t q_status;
  pvfe_back_ctl_t back_ctl;
  pvfe_byte_t     push_data;
  pvfe_byte_t     q_data;
  logic           push;

  // Byte intake
  pvfe_front u_front (
    .msg       (msg),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue
  pvfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .ctl       (back_ctl),
    .pop_data  (q_data),
    .status    (q_status)
  );

  // Parser and result register
  pvfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_status    (q_status),
    .q_data      (q_data),
    .ctl         (back_ctl),
    .res         (res)
  );

  // Checks
  `PVFE_ASSERT_IMPL(a_full_blocks_input, clk, rst, q_status.full, !msg.ready,
    "ready with queue full")
  `PVFE_ASSERT_IMPL(a_pop_not_empty, clk, rst, back_ctl.pop, !q_status.empty,
    "pop from empty queue")
  `PVFE_ASSERT_IMPL(a_value_zero, clk, rst, res.valid && (res.outcome != OUT_FOUND),
    res.field_value == '0, "value set on non-found result")
  `PVFE_ASSERT_NEXT(a_push_fills, clk, rst, msg.valid && msg.ready && q_status.empty,
    !q_status.empty, "byte lost in queue")

endmodule

// ----- sim/protobuf_varint_field_extract_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for protobuf_varint_field_extract_unit: byte stimulus, a
// bit-accurate parser model and a result scoreboard. Needs pvfe_pkg, pvfe_if and the RTL.
module protobuf_varint_field_extract_unit_tb;
  import pvfe_pkg::*;

  localparam int HALF_PERIOD_NS = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TIMEOUT_NS     = 5_000_000;
  localparam int PHASE_BYTES    = 60;
  localparam int NUM_SETTINGS   = 5;

  // Wire types the block does not handle
  localparam logic [2:0] WT_SGROUP = 3'd3;
  localparam logic [2:0] WT_EGROUP = 3'd4;
  localparam logic [2:0] WT_RSVD6  = 3'd6;
  localparam logic [2:0] WT_RSVD7  = 3'd7;

  typedef struct packed {
    logic [MSG_BYTE_W-1:0] data;
    logic                  last;
  } msg_byte_t;

  typedef struct packed {
    pvfe_outcome_t              outcome;
    logic signed [VALUE_W-1:0]  fval;
  } extract_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [FIELD_NUM_W-1:0] cfg_wr_data;

  pvfe_byte_if   msg_if ();
  pvfe_result_if res_if ();

  protobuf_varint_field_extract_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .msg         (msg_if),
    .res         (res_if)
  );

  always begin
    #HALF_PERIOD_NS clk = 1'b1;
    #HALF_PERIOD_NS clk = 1'b0;
  end

  // Parser model state
  logic [FIELD_NUM_W-1:0] wanted_fn;
  pvfe_phase_t            parse_ph;
  logic [ACCUM_W-1:0]     vacc;
  logic [3:0]             vbytes;
  logic [ACCUM_W-1:0]     skip_left;
  logic                   msg_decided;

  // Stimulus and scoreboard
  msg_byte_t              pending_bytes[$];
  logic [MSG_BYTE_W-1:0]  msg_buf[$];
  extract_result_t        results_due[$];
  logic [FIELD_NUM_W-1:0] fn_settings[NUM_SETTINGS];
  int                     pushed_count = 0;
  int                     taken_count  = 0;
  int                     mismatches   = 0;
  logic                   byte_taken   = 1'b0;
  int                     gap_left     = 0;
  int                     burst_left   = 0;
  msg_byte_t              cur_byte;
  logic [15:0]            stall_pat    = 16'hFFFF;
  int                     stall_cyc    = 0;
  logic                   step_emitted;
  extract_result_t        step_res;
  extract_result_t        due_res;

  function automatic void reset_parser();
    parse_ph    = PH_KEY;
    vacc        = '0;
    vbytes      = '0;
    skip_left   = '0;
    msg_decided = 1'b0;
  endfunction

  // One message byte through the parser model; at most one result comes out
  function automatic void parse_byte(input logic [MSG_BYTE_W-1:0] b, input logic last,
                                     output logic emitted, output extract_result_t r);
    logic [ACCUM_W-1:0] v;
    emitted   = 1'b0;
    r.outcome = OUT_FOUND;
    r.fval    = '0;
    // result already given: drop to the end of the message
    if (msg_decided) begin
      if (last) reset_parser();
      return;
    end
    if (parse_ph == PH_SKIPBYTES) begin
      if (skip_left != '0) skip_left = skip_left - 1'b1;
      if (skip_left == '0) parse_ph = PH_KEY;
      if (last) begin
        emitted   = 1'b1;
        r.outcome = OUT_ABSENT;
      end
    end else begin
      vacc = vacc | (ACCUM_W'(b[6:0]) << (7 * int'(vbytes)));
      if (b[7]) begin
        vbytes = vbytes + 4'd1;
        if (vbytes >= MAX_VARINT_BYTES) begin
          emitted   = 1'b1;
          r.outcome = OUT_TOO_LONG;
        end else if (last) begin
          emitted   = 1'b1;
          r.outcome = OUT_TRUNC;
        end
      end else begin
        v      = vacc;
        vacc   = '0;
        vbytes = '0;
        case (parse_ph)
          PH_VALUE: begin
            emitted = 1'b1;
            r.fval  = v[VALUE_W-1:0];
          end
          PH_SKIPVAR: begin
            parse_ph = PH_KEY;
            if (last) begin
              emitted   = 1'b1;
              r.outcome = OUT_ABSENT;
            end
          end
          PH_LEN: begin
            if (v == '0) begin
              parse_ph = PH_KEY;
            end else begin
              skip_left = v;
              parse_ph  = PH_SKIPBYTES;
            end
            if (last) begin
              emitted   = 1'b1;
              r.outcome = OUT_ABSENT;
            end
          end
          default: begin
            // key: full field number compared, wrong type ahead of unsupported type
            if ((v >> 3) == ACCUM_W'(wanted_fn)) begin
              if (v[2:0] == WT_VARINT) begin
                parse_ph = PH_VALUE;
                if (last) begin
                  emitted   = 1'b1;
                  r.outcome = OUT_TRUNC;
                end
              end else begin
                emitted   = 1'b1;
                r.outcome = OUT_WRONG_TYPE;
              end
            end else if (v[2:0] == WT_VARINT || v[2:0] == WT_LEN) begin
              parse_ph = (v[2:0] == WT_VARINT) ? PH_SKIPVAR : PH_LEN;
              if (last) begin
                emitted   = 1'b1;
                r.outcome = OUT_TRUNC;
              end
            end else if (v[2:0] == WT_I64 || v[2:0] == WT_I32) begin
              skip_left = (v[2:0] == WT_I64) ? SKIP_I64 : SKIP_I32;
              parse_ph  = PH_SKIPBYTES;
              if (last) begin
                emitted   = 1'b1;
                r.outcome = OUT_ABSENT;
              end
            end else begin
              emitted   = 1'b1;
              r.outcome = OUT_UNSUP_TYPE;
            end
          end
        endcase
      end
    end
    if (emitted && !last) begin
      msg_decided = 1'b1;
      vacc        = '0;
      vbytes      = '0;
      skip_left   = '0;
      parse_ph    = PH_KEY;
    end else if (last) begin
      reset_parser();
    end
  endfunction

  // Message building
  function automatic void add_varint(input logic [63:0] v, input int pad);
    logic [63:0] rest;
    logic        fin;
    rest = v;
    fin  = 1'b0;
    // pad adds redundant zero groups after the significant ones
    while (!fin) begin
      if (rest[63:7] == '0 && pad == 0) begin
        msg_buf.push_back({1'b0, rest[6:0]});
        fin = 1'b1;
      end else begin
        msg_buf.push_back({1'b1, rest[6:0]});
        if (rest[63:7] == '0) pad--;
        rest = rest >> 7;
      end
    end
  endfunction

  function automatic void add_random_bytes(input int n);
    repeat (n) msg_buf.push_back(MSG_BYTE_W'($urandom));
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 4)) : 0;
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 4))
      0:       v = 64'($urandom_range(0, 127));
      1:       v = 64'($urandom_range(0, 65535));
      2:       v = 64'($urandom);
      3:       v = {32'($urandom), 32'($urandom)};
      default: v = {32'hFFFF_FFFF, 32'($urandom) | 32'h8000_0000};
    endcase
    return v;
  endfunction

  function automatic logic [63:0] pick_other_fn();
    logic [63:0] fn;
    case ($urandom_range(0, 4))
      0:       fn = 64'(wanted_fn) + 64'($urandom_range(1, 3));
      1:       fn = 64'($urandom_range(0, 20));
      2:       fn = 64'(FIELD_NUM_W'($urandom));
      3:       fn = 64'(wanted_fn ^ (FIELD_NUM_W'(1) << $urandom_range(0, FIELD_NUM_W-1)));
      default: fn = {4'b0001, 28'($urandom), 32'($urandom)};
    endcase
    if (fn == 64'(wanted_fn)) fn = fn + 64'd1;
    return fn;
  endfunction

  // A field that never matches: any wire type, unsupported ones now and then
  function automatic void add_other_field();
    logic [2:0] wt;
    int         len;
    case ($urandom_range(0, 9))
      0, 1, 2: wt = WT_VARINT;
      3, 4:    wt = WT_LEN;
      5, 6:    wt = WT_I64;
      7, 8:    wt = WT_I32;
      default: begin
        case ($urandom_range(0, 3))
          0:       wt = WT_SGROUP;
          1:       wt = WT_EGROUP;
          2:       wt = WT_RSVD6;
          default: wt = WT_RSVD7;
        endcase
      end
    endcase
    add_varint((pick_other_fn() << 3) | 64'(wt), pick_pad());
    if (wt == WT_VARINT) begin
      add_varint(pick_value(), pick_pad());
    end else if (wt == WT_I64) begin
      add_random_bytes(int'(SKIP_I64));
    end else if (wt == WT_I32) begin
      add_random_bytes(int'(SKIP_I32));
    end else if (wt == WT_LEN) begin
      len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(7, 24))
                                        : int'($urandom_range(0, 6));
      add_varint(64'(len), pick_pad());
      add_random_bytes(len);
    end
  endfunction

  function automatic void build_random_message();
    int kind;
    int cut;
    msg_buf.delete();
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      // noise, or a run of continuation bytes
      if ($urandom_range(0, 1) == 0) begin
        add_random_bytes($urandom_range(1, 12));
      end else begin
        repeat ($urandom_range(1, 12)) msg_buf.push_back(MSG_BYTE_W'($urandom) | 8'h80);
      end
    end else begin
      repeat ($urandom_range(0, 3)) add_other_field();
      if (kind == 1) begin
        add_varint((64'(wanted_fn) << 3) | 64'($urandom_range(1, 7)), pick_pad());
      end else if (kind > 3) begin
        add_varint((64'(wanted_fn) << 3) | 64'(WT_VARINT), pick_pad());
        add_varint(pick_value(), pick_pad());
      end
      repeat ($urandom_range(0, 2)) add_other_field();
      if (msg_buf.size() == 0) add_other_field();
      // cut short now and then
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, msg_buf.size());
        while (msg_buf.size() > cut) void'(msg_buf.pop_back());
      end
    end
  endfunction

  function automatic int queue_message();
    msg_byte_t item;
    foreach (msg_buf[i]) begin
      item.data = msg_buf[i];
      item.last = (i == msg_buf.size() - 1);
      pending_bytes.push_back(item);
    end
    pushed_count += msg_buf.size();
    return msg_buf.size();
  endfunction

  task automatic queue_random_messages(input int nbytes);
    int sent;
    sent = 0;
    while (sent < nbytes) begin
      build_random_message();
      sent += queue_message();
    end
  endtask

  // Directed messages, field 1 wanted
  task automatic queue_directed();
    msg_buf = '{8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h07};                // largest positive
    void'(queue_message());
    msg_buf = '{8'h12, 8'h00, 8'h08, 8'h80, 8'h80, 8'h80, 8'h80, 8'h08};  // empty run, then min
    void'(queue_message());
    msg_buf = '{8'h10, 8'h05};                  // varint skipped to the end
    void'(queue_message());
    msg_buf = '{8'h09, 8'hFF};                  // wrong type, tail dropped
    void'(queue_message());
    msg_buf = '{8'h0B};                         // wrong type wins over unsupported type
    void'(queue_message());
    msg_buf = '{8'h13};                         // unsupported type
    void'(queue_message());
    msg_buf = '{8'h08};                         // matching key ends the message
    void'(queue_message());
    msg_buf = '{8'h1A};                         // length key ends the message
    void'(queue_message());
    msg_buf = '{8'h15, 8'hAA, 8'hBB, 8'hCC, 8'hDD};  // fixed 32 ends exactly at the end
    void'(queue_message());
    msg_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};   // overlong key on the final byte
    void'(queue_message());
  endtask

  // Wait until every byte is taken and every result is back, then let the pipe settle
  task automatic wait_idle();
    while (taken_count != pushed_count || results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_wanted(input logic [FIELD_NUM_W-1:0] fn);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fn;
    wanted_fn    = fn;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Byte driver: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst) begin
      msg_if.valid <= 1'b0;
    end else if (!msg_if.valid || byte_taken) begin
      if (gap_left > 0 || pending_bytes.size() == 0) begin
        if (gap_left > 0) gap_left--;
        msg_if.valid <= 1'b0;
      end else begin
        cur_byte = pending_bytes.pop_front();
        msg_if.valid    <= 1'b1;
        msg_if.msg_byte <= cur_byte.data;
        msg_if.msg_last <= cur_byte.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 12));
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Result sink: ready follows a 16-bit stall pattern that is redrawn at random
  always @(negedge clk) begin
    stall_cyc++;
    if (stall_cyc % 64 == 0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
    res_if.ready <= rst ? 1'b0 : stall_pat[stall_cyc % 16];
  end

  // Monitor: predict on each byte transfer, check each result transfer
  always @(posedge clk) begin
    byte_taken <= !rst && msg_if.valid && msg_if.ready;
    if (!rst && msg_if.valid && msg_if.ready) begin
      taken_count++;
      parse_byte(msg_if.msg_byte, msg_if.msg_last, step_emitted, step_res);
      if (step_emitted) results_due.push_back(step_res);
    end
    if (!rst && res_if.valid && res_if.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, outcome %0d value %0d",
                 $time, res_if.outcome, res_if.field_value);
        mismatches++;
      end else begin
        due_res = results_due.pop_front();
        if (res_if.outcome !== due_res.outcome) begin
          $display("%0t: outcome expected %0d actual %0d",
                   $time, due_res.outcome, res_if.outcome);
          mismatches++;
        end
        if (res_if.field_value !== due_res.fval) begin
          $display("%0t: field_value expected %0d actual %0d",
                   $time, due_res.fval, res_if.field_value);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: directed and random messages at the reset setting, then one random phase per setting
  initial begin
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    msg_if.valid    = 1'b0;
    msg_if.msg_byte = '0;
    msg_if.msg_last = 1'b0;
    res_if.ready    = 1'b0;
    wanted_fn       = WANTED_RESET;
    reset_parser();
    fn_settings = '{'0, '1, FIELD_NUM_W'(16), FIELD_NUM_W'($urandom), WANTED_RESET};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_directed();
    queue_random_messages(PHASE_BYTES - 15);
    wait_idle();
    foreach (fn_settings[k]) begin
      write_wanted(fn_settings[k]);
      queue_random_messages(PHASE_BYTES);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", results_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- protobuf_varint_field_extract_unit.f -----
+incdir+rtl
rtl/pvfe_pkg.sv
rtl/pvfe_if.sv
rtl/pvfe_front.sv
rtl/pvfe_queue.sv
rtl/pvfe_back.sv
rtl/protobuf_varint_field_extract_unit.sv
sim/protobuf_varint_field_extract_unit_tb.sv
